// ===== design/arxf_pkg.sv =====
// ----------------------------------------------------------------------------
// arxf_pkg: shared definitions for the ARX difference-equation filter
// Field widths, register indexes, default sizes and the structs that pass
// between the filter's modules.
// ----------------------------------------------------------------------------
package arxf_pkg;

   // default sizes for the top-level parameters
   localparam int DEF_MAX_FEEDBACK    = 4;
   localparam int DEF_MAX_FEEDFORWARD = 3;
   localparam int DEF_MAX_DELAY       = 8;
   localparam int DEF_SAMPLE_WIDTH    = 16;

   // coefficient format: Q2.13 in 16-bit lanes, four lanes per register
   localparam int COEF_W     = 16;
   localparam int COEF_LANES = 4;
   localparam int FRAC_BITS  = 13;
   localparam int GUARD_BITS = 4;   // room for up to 2*COEF_LANES products

   // register field widths
   localparam int NA_W       = 3;
   localparam int NB_W       = 2;
   localparam int ND_W       = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_ORDER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDFORWARD_ORDER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_DELAY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A_PACKED     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B_PACKED     = 3'd4;

   // orders and delay, already clamped to the supported range
   typedef struct packed {
      logic [NA_W-1:0] na;
      logic [NB_W-1:0] nb;
      logic [ND_W-1:0] nd;
   } cfg_type;

   // history line control
   typedef struct packed {
      logic step;      // an item was accepted: shift both lines
      logic clr_in;    // clear the input line
      logic clr_out;   // clear the output line
   } hist_ctl_type;

endpackage

// ===== design/arxf_mac.sv =====
// ----------------------------------------------------------------------------
// arxf_mac: multiply-add, rounding and saturation
// Forms -sum(a_i*y) + sum(b_j*u) from the history taps in one pass,
// rounds half-up from Q.13 and clamps to the sample width.
// ----------------------------------------------------------------------------
module arxf_mac import arxf_pkg::*; #(
   parameter int MAX_FEEDBACK    = DEF_MAX_FEEDBACK,
   parameter int MAX_FEEDFORWARD = DEF_MAX_FEEDFORWARD,
   parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH
) (
   input  cfg_type                        cfg,
   input  logic [CSR_DATA_W-1:0]          coef_a,
   input  logic [CSR_DATA_W-1:0]          coef_b,
   input  logic signed [SAMPLE_WIDTH-1:0] y_hist [MAX_FEEDBACK],
   input  logic signed [SAMPLE_WIDTH-1:0] u_tap  [MAX_FEEDFORWARD+1],
   output logic signed [SAMPLE_WIDTH-1:0] y,
   output logic                           clip
);

   // lanes past the fourth read as zero, so they get no multiplier
   localparam int NA_TAPS = (MAX_FEEDBACK < COEF_LANES) ? MAX_FEEDBACK : COEF_LANES;
   localparam int NB_TAPS = (MAX_FEEDFORWARD + 1 < COEF_LANES) ?
                            (MAX_FEEDFORWARD + 1) : COEF_LANES;
   localparam int PROD_W  = COEF_W + SAMPLE_WIDTH;
   localparam int ACC_W   = PROD_W + GUARD_BITS;

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_HI   =
      ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

   logic signed [PROD_W-1:0] prod_a [NA_TAPS];
   logic signed [PROD_W-1:0] prod_b [NB_TAPS];
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [ACC_W-1:0]  scaled;

   for (genvar i = 0; i < NA_TAPS; i++) begin : g_prod_a
      assign prod_a[i] = signed'(coef_a[i*COEF_W +: COEF_W]) * y_hist[i];
   end

   for (genvar j = 0; j < NB_TAPS; j++) begin : g_prod_b
      assign prod_b[j] = signed'(coef_b[j*COEF_W +: COEF_W]) * u_tap[j];
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA_TAPS; i++) begin
         if (NA_W'(i) < cfg.na) begin
            acc = acc - ACC_W'(prod_a[i]);
         end
      end
      for (int j = 0; j < NB_TAPS; j++) begin
         if (NB_W'(j) <= cfg.nb) begin
            acc = acc + ACC_W'(prod_b[j]);
         end
      end
      rnd    = acc + RND_HALF;
      scaled = rnd >>> FRAC_BITS;   // arithmetic shift is a floor
   end

   always_comb begin
      if (scaled > SAT_HI) begin
         y    = SAT_HI[SAMPLE_WIDTH-1:0];
         clip = 1'b1;
      end else if (scaled < SAT_LO) begin
         y    = SAT_LO[SAMPLE_WIDTH-1:0];
         clip = 1'b1;
      end else begin
         y    = scaled[SAMPLE_WIDTH-1:0];
         clip = 1'b0;
      end
   end

endmodule

// ===== design/arxf_hist.sv =====
// ----------------------------------------------------------------------------
// arxf_hist: input delay line and output history
// The input line inserts each sample at a point set by the delay, so the
// feedforward taps sit at fixed positions. The output line is a plain shift.
// ----------------------------------------------------------------------------
module arxf_hist import arxf_pkg::*; #(
   parameter int MAX_FEEDBACK    = DEF_MAX_FEEDBACK,
   parameter int MAX_FEEDFORWARD = DEF_MAX_FEEDFORWARD,
   parameter int MAX_DELAY       = DEF_MAX_DELAY,
   parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hist_ctl_type                   ctl,
   input  logic [ND_W-1:0]                nd,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic signed [SAMPLE_WIDTH-1:0] y_new,
   output logic signed [SAMPLE_WIDTH-1:0] u_tap  [MAX_FEEDFORWARD+1],
   output logic signed [SAMPLE_WIDTH-1:0] y_hist [MAX_FEEDBACK]
);

   localparam int IN_DEPTH = MAX_DELAY + MAX_FEEDFORWARD;

   // Entry t holds u[k-1-(t-(MAX_DELAY-nd))]; entries below the insertion
   // point are never tapped.
   logic signed [SAMPLE_WIDTH-1:0] in_line_ff  [IN_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] in_line_in  [IN_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] in_prev     [IN_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] out_line_ff [MAX_FEEDBACK];
   logic signed [SAMPLE_WIDTH-1:0] out_line_in [MAX_FEEDBACK];
   logic signed [SAMPLE_WIDTH-1:0] out_prev    [MAX_FEEDBACK];

   for (genvar t = 0; t < IN_DEPTH; t++) begin : g_in_prev
      if (t == 0) begin : g_head
         assign in_prev[t] = sample;
      end else begin : g_body
         assign in_prev[t] = in_line_ff[t-1];
      end
   end

   for (genvar t = 0; t < MAX_FEEDBACK; t++) begin : g_out_prev
      if (t == 0) begin : g_head
         assign out_prev[t] = y_new;
      end else begin : g_body
         assign out_prev[t] = out_line_ff[t-1];
      end
   end

   always_comb begin
      for (int t = 0; t < IN_DEPTH; t++) begin
         in_line_in[t] = in_line_ff[t];
         if (ctl.clr_in) begin
            in_line_in[t] = '0;
         end else if (ctl.step) begin
            in_line_in[t] = ((t + int'(nd)) <= MAX_DELAY) ? sample : in_prev[t];
         end
      end
      for (int t = 0; t < MAX_FEEDBACK; t++) begin
         out_line_in[t] = out_line_ff[t];
         if (ctl.clr_out) begin
            out_line_in[t] = '0;
         end else if (ctl.step) begin
            out_line_in[t] = out_prev[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < IN_DEPTH; t++) begin
            in_line_ff[t] <= '0;
         end
         for (int t = 0; t < MAX_FEEDBACK; t++) begin
            out_line_ff[t] <= '0;
         end
      end else begin
         in_line_ff  <= in_line_in;
         out_line_ff <= out_line_in;
      end
   end

   for (genvar j = 0; j <= MAX_FEEDFORWARD; j++) begin : g_tap
      assign u_tap[j] = in_line_ff[MAX_DELAY-1+j];
   end

   assign y_hist = out_line_ff;

endmodule

// ===== design/arxf_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// arxf_rsp_queue: two-entry result queue
// Holds finished results so the input side keeps going while the output
// side stalls. Ready depends on registered state only.
// ----------------------------------------------------------------------------
module arxf_rsp_queue #(
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] in_data,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

// ===== design/arx_difference_equation_filter.sv =====
// ----------------------------------------------------------------------------
// arx_difference_equation_filter: fixed-point ARX / IIR filter
// Computes y = -sum(a_i*y[k-i]) + sum(b_j*u[k-nd-j]) per input item.
// ----------------------------------------------------------------------------
// The filter takes one sample per clock while req_ready is high and returns
// one result per sample. A result is first registered in the result queue;
// the whole multiply-add, the half-up rounding from Q.13 and the saturation
// are combinational, because each result feeds the next one through the output
// history. A two-entry result queue sits on the output, so req_ready only
// drops after two results are left waiting. The current sample does not
// affect its own result: it enters the input history and reaches the output
// after input_delay items. Writing feedback_order clears the output history,
// writing feedforward_order or input_delay clears the input history, and
// out-of-range orders and delays are clamped when written. Write the
// registers only while no item is in flight.
// ----------------------------------------------------------------------------
module arx_difference_equation_filter import arxf_pkg::*; #(
   parameter int MAX_FEEDBACK    = DEF_MAX_FEEDBACK,
   parameter int MAX_FEEDFORWARD = DEF_MAX_FEEDFORWARD,
   parameter int MAX_DELAY       = DEF_MAX_DELAY,
   parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_out,
   output logic                           rsp_clipped,
   // register writes
   input  logic                           csr_wen,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata
);

   localparam int RSP_W = SAMPLE_WIDTH + 1;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [CSR_DATA_W-1:0] coef_a_ff;
   logic [CSR_DATA_W-1:0] coef_a_in;
   logic [CSR_DATA_W-1:0] coef_b_ff;
   logic [CSR_DATA_W-1:0] coef_b_in;
   logic [NA_W-1:0]       na_wr;
   logic [NB_W-1:0]       nb_wr;
   logic [ND_W-1:0]       nd_wr;

   // clamp written values to what the history lines support
   always_comb begin
      na_wr = csr_wdata[NA_W-1:0];
      if (int'(na_wr) > MAX_FEEDBACK) begin
         na_wr = NA_W'(MAX_FEEDBACK);
      end
      nb_wr = csr_wdata[NB_W-1:0];
      if (int'(nb_wr) > MAX_FEEDFORWARD) begin
         nb_wr = NB_W'(MAX_FEEDFORWARD);
      end
      nd_wr = csr_wdata[ND_W-1:0];
      if (nd_wr == '0) begin
         nd_wr = ND_W'(1);
      end else if (int'(nd_wr) > MAX_DELAY) begin
         nd_wr = ND_W'(MAX_DELAY);
      end
   end

   always_comb begin
      cfg_in    = cfg_ff;
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_FEEDBACK_ORDER:    cfg_in.na = na_wr;
            CSR_FEEDFORWARD_ORDER: cfg_in.nb = nb_wr;
            CSR_INPUT_DELAY:       cfg_in.nd = nd_wr;
            CSR_COEF_A_PACKED:     coef_a_in = csr_wdata;
            CSR_COEF_B_PACKED:     coef_b_in = csr_wdata;
            default: ;   // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.na <= '0;
         cfg_ff.nb <= '0;
         cfg_ff.nd <= ND_W'(1);
         coef_a_ff <= '0;
         coef_b_ff <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         coef_a_ff <= coef_a_in;
         coef_b_ff <= coef_b_in;
      end
   end

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   hist_ctl_type                   hist_ctl;
   logic                           req_accept;
   logic signed [SAMPLE_WIDTH-1:0] u_tap  [MAX_FEEDFORWARD+1];
   logic signed [SAMPLE_WIDTH-1:0] y_hist [MAX_FEEDBACK];
   logic signed [SAMPLE_WIDTH-1:0] y_new;
   logic                           clip_new;
   logic [RSP_W-1:0]               rsp_data;

   assign req_accept = req_valid && req_ready;

   // a clear wins over a shift in the history lines
   assign hist_ctl.step    = req_accept;
   assign hist_ctl.clr_out = csr_wen && (csr_index == CSR_FEEDBACK_ORDER);
   assign hist_ctl.clr_in  = csr_wen && ((csr_index == CSR_FEEDFORWARD_ORDER) ||
                                         (csr_index == CSR_INPUT_DELAY));

   arxf_hist #(
      .MAX_FEEDBACK    (MAX_FEEDBACK),
      .MAX_FEEDFORWARD (MAX_FEEDFORWARD),
      .MAX_DELAY       (MAX_DELAY),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (hist_ctl),
      .nd     (cfg_ff.nd),
      .sample (req_sample_in),
      .y_new  (y_new),
      .u_tap  (u_tap),
      .y_hist (y_hist)
   );

   // result of the accepted item, formed from the history before the shift
   arxf_mac #(
      .MAX_FEEDBACK    (MAX_FEEDBACK),
      .MAX_FEEDFORWARD (MAX_FEEDFORWARD),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH)
   ) u_mac (
      .cfg    (cfg_ff),
      .coef_a (coef_a_ff),
      .coef_b (coef_b_ff),
      .y_hist (y_hist),
      .u_tap  (u_tap),
      .y      (y_new),
      .clip   (clip_new)
   );

   arxf_rsp_queue #(
      .DATA_W (RSP_W)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   ({clip_new, y_new}),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_filtered_out = rsp_data[SAMPLE_WIDTH-1:0];
   assign rsp_clipped      = rsp_data[SAMPLE_WIDTH];

`ifndef SYNTHESIS
   // every accepted item lands in the result queue
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted item left no result");

   // a clipped result sits at one of the rails
   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         ((rsp_filtered_out == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}) ||
          (rsp_filtered_out == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})))
      else $error("clip flag set on an unsaturated result");

   // the stored delay always lands the taps inside the input line
   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      (cfg_ff.nd != '0) && (int'(cfg_ff.nd) <= MAX_DELAY))
      else $error("input delay out of range");

   // writing the feedback order empties the output history
   a_fb_clear: assert property (@(posedge clock) disable iff (reset)
      (csr_wen && (csr_index == CSR_FEEDBACK_ORDER)) |=> (y_hist[0] == '0))
      else $error("output history not cleared");
`endif

endmodule
